// File: design/sgd_pkg.sv
`default_nettype none
package sgd_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int MAX_HEIGHT        = 4096;
  localparam int CORDIC_STEPS      = 20;
  localparam int STEP_W            = 5;
  localparam int HALF_PI_Q13       = 12868;
  localparam int MAG_MAX           = 255;
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  localparam int GRAD_W = 11;
  localparam int XY_W   = 34;
  localparam int Z_W    = 23;
  localparam int SQ_W   = 22;

  // Register index is bit 2 of the byte address.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_CALC,
    ST_HOLD
  } sgd_state_t;

  // atan(2^-i) in Q.20, rounded.
  function automatic logic signed [Z_W-1:0] atan_q20(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    begin
      unique case (i)
        5'd0:  v = 23'sd823550;
        5'd1:  v = 23'sd486170;
        5'd2:  v = 23'sd256879;
        5'd3:  v = 23'sd130396;
        5'd4:  v = 23'sd65451;
        5'd5:  v = 23'sd32757;
        5'd6:  v = 23'sd16383;
        5'd7:  v = 23'sd8192;
        5'd8:  v = 23'sd4096;
        5'd9:  v = 23'sd2048;
        5'd10: v = 23'sd1024;
        5'd11: v = 23'sd512;
        5'd12: v = 23'sd256;
        5'd13: v = 23'sd128;
        5'd14: v = 23'sd64;
        5'd15: v = 23'sd32;
        5'd16: v = 23'sd16;
        5'd17: v = 23'sd8;
        5'd18: v = 23'sd4;
        5'd19: v = 23'sd2;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// File: design/sgd_ifs.sv
`default_nettype none
interface sgd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sgd_grad_if;
  logic               valid;
  logic               ready;
  logic [7:0]         magnitude;
  logic signed [14:0] direction;
  logic [11:0]        center_row;
  logic [10:0]        center_col;
  logic               frame_last;
  modport source (output valid, output magnitude, output direction, output center_row,
                  output center_col, output frame_last, input ready);
  modport sink (input valid, input magnitude, input direction, input center_row,
                input center_col, input frame_last, output ready);
endinterface
`default_nettype wire

// File: design/sgd_calc.sv
`default_nettype none
module sgd_calc
  import sgd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [GRAD_W-1:0] gx,
  input  wire logic signed [GRAD_W-1:0] gy,
  output logic                          done,
  output logic [7:0]                    magnitude,
  output logic signed [14:0]            direction
);

  logic                    busy;
  logic [STEP_W-1:0]       step;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic [SQ_W-1:0]         rem;
  logic [SQ_W-1:0]         root;
  logic [SQ_W-1:0]         sq_bit;
  logic                    gx_neg;
  logic                    gy_neg;
  logic                    gx_zero;

  logic [GRAD_W-1:0]       ax;
  logic [GRAD_W-1:0]       ay;
  logic signed [2*GRAD_W-1:0] sqx;
  logic signed [2*GRAD_W-1:0] sqy;
  logic [SQ_W-1:0]         trial;
  logic signed [Z_W-1:0]   zr;
  logic signed [Z_W-1:0]   q;
  logic signed [14:0]      qc;

  always_comb begin
    ax    = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
    ay    = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
    sqx   = gx * gx;
    sqy   = gy * gy;
    trial = root + sq_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x       <= XY_W'({ax, 20'd0});
      y       <= XY_W'({ay, 20'd0});
      z       <= '0;
      rem     <= SQ_W'(sqx + sqy);
      root    <= '0;
      sq_bit  <= SQ_W'(1) << 20;
      gx_neg  <= gx[GRAD_W-1];
      gy_neg  <= gy[GRAD_W-1];
      gx_zero <= (gx == '0);
    end else if (busy) begin
      if (!y[XY_W-1]) begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + atan_q20(step);
      end else begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - atan_q20(step);
      end
      // Bit-pair square root runs alongside the first eleven angle steps.
      if (sq_bit != '0) begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
    end
  end

  always_comb begin
    zr = z + Z_W'(64);
    q  = zr >>> 7;
    if (q < 0) begin
      qc = '0;
    end else if (q > Z_W'(HALF_PI_Q13)) begin
      qc = 15'(HALF_PI_Q13);
    end else begin
      qc = q[14:0];
    end
    if (gx_zero) begin
      direction = (!gy_neg && (root != '0 || rem != '0)) ? 15'(HALF_PI_Q13)
                                                         : -15'(HALF_PI_Q13);
    end else if (gx_neg != gy_neg) begin
      direction = -qc;
    end else begin
      direction = qc;
    end
    magnitude = (root > SQ_W'(MAG_MAX)) ? 8'(MAG_MAX) : root[7:0];
  end

endmodule
`default_nettype wire

// File: design/sobel_gradient_direction.sv
`default_nettype none
// Sobel 3x3 gradient magnitude and direction over a raster pixel stream.
// Pixels enter on the pixels channel (valid/ready), one grey value per item,
// with frame_start marking the first pixel of a frame. For each pixel that
// completes a window with an interior center, one item leaves on the
// gradients channel: the saturated magnitude, the angle in Q2.13 radians,
// the center position and a flag on the last result of the frame.
// Frame geometry is set through the APB port: frame_width at 0x0,
// frame_height at 0x4; write only while the block is idle.
// One pixel is worked on at a time. A border pixel goes through accept, then
// the line store read and write. An interior pixel goes through the line store
// read, the gradient register, 20 steps of the shared CORDIC/square root unit
// and the load of the output register.
// The result sits in an output register, so the next pixel is accepted
// while it waits; a stalled receiver holds the block only when a second
// result is ready to be loaded. Reset clears position, window and geometry
// to 640x480; the line stores are not cleared and need no clearing pass.
module sobel_gradient_direction
  import sgd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  sgd_pixel_if.sink        pixels,
  sgd_grad_if.source       gradients
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > 12) ? WW0 : 12;

  logic [11:0] frame_width;
  logic [12:0] frame_height;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(frame_height) : 32'(frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'(FRAME_WIDTH_RESET);
      frame_height <= 13'(FRAME_HEIGHT_RESET);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[11:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[12:0];
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;

  always_comb begin
    if (WW'(frame_width) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height < 13'd3) begin
      h_eff = 13'd3;
    end else if (frame_height > 13'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  sgd_state_t    state;
  sgd_state_t    state_next;
  logic [CW-1:0] column_count;
  logic [11:0]   row_count;

  logic          accept;
  logic [CW-1:0] cur_col;
  logic [11:0]   cur_row;
  logic [12:0]   row_tmp;
  logic [WW-1:0] col_inc;
  logic [12:0]   row_inc;
  logic [CW-1:0] col_after;
  logic [11:0]   row_after;

  assign accept = pixels.valid && pixels.ready;

  // Position of the incoming pixel, with wrap for geometry changes.
  always_comb begin
    cur_col = pixels.frame_start ? '0 : column_count;
    row_tmp = pixels.frame_start ? 13'd0 : 13'(row_count);
    if (WW'(cur_col) >= w_eff) begin
      cur_col = '0;
      row_tmp = row_tmp + 13'd1;
    end
    if (row_tmp >= h_eff) begin
      row_tmp = 13'd0;
    end
    cur_row = row_tmp[11:0];
    col_inc = WW'(cur_col) + WW'(1);
    row_inc = 13'(cur_row) + 13'd1;
    if (col_inc >= w_eff) begin
      col_after = '0;
      row_after = (row_inc >= h_eff) ? 12'd0 : row_inc[11:0];
    end else begin
      col_after = col_inc[CW-1:0];
      row_after = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= col_after;
      row_count    <= row_after;
    end
  end

  logic [7:0]    upper [MAX_WIDTH];
  logic [7:0]    middle [MAX_WIDTH];
  logic [7:0]    top_rd;
  logic [7:0]    mid_rd;
  logic [7:0]    pix_q;
  logic [CW-1:0] col_q;
  logic [11:0]   row_q;
  logic          interior_q;
  logic          last_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd     <= upper[cur_col];
      mid_rd     <= middle[cur_col];
      pix_q      <= pixels.pixel;
      col_q      <= cur_col;
      row_q      <= cur_row;
      interior_q <= (cur_row >= 12'd2) && (WW'(cur_col) >= WW'(2));
      last_q     <= (13'(cur_row) == h_eff - 13'd1) && (WW'(cur_col) == w_eff - WW'(1));
    end
    if (state == ST_READ) begin
      upper[col_q]  <= mid_rd;
      middle[col_q] <= pix_q;
    end
  end

  logic [7:0] win0, win1, win2, win3, win4, win5;
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic signed [GRAD_W-1:0] gx_q;
  logic signed [GRAD_W-1:0] gy_q;

  always_comb begin
    gx = GRAD_W'({2'b0, top_rd} + {1'b0, mid_rd, 1'b0} + {2'b0, pix_q})
       - GRAD_W'({2'b0, win0} + {1'b0, win1, 1'b0} + {2'b0, win2});
    gy = GRAD_W'({2'b0, win0} + {1'b0, win3, 1'b0} + {2'b0, top_rd})
       - GRAD_W'({2'b0, win2} + {1'b0, win5, 1'b0} + {2'b0, pix_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0; win1 <= '0; win2 <= '0;
      win3 <= '0; win4 <= '0; win5 <= '0;
    end else if (state == ST_READ) begin
      win0 <= win3; win1 <= win4; win2 <= win5;
      win3 <= top_rd; win4 <= mid_rd; win5 <= pix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      gx_q <= gx;
      gy_q <= gy;
    end
  end

  logic               calc_start;
  logic               calc_done;
  logic [7:0]         calc_mag;
  logic signed [14:0] calc_dir;

  sgd_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .start     (calc_start),
    .gx        (gx_q),
    .gy        (gy_q),
    .done      (calc_done),
    .magnitude (calc_mag),
    .direction (calc_dir)
  );

  logic out_free;
  logic load;

  assign out_free = !gradients.valid || gradients.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = interior_q ? ST_START : ST_IDLE;
      ST_START: state_next = ST_CALC;
      ST_CALC:  if (calc_done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pixels.ready = (state == ST_IDLE);
    calc_start   = (state == ST_START);
    load         = (state == ST_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [WW-1:0] col_m1;
  assign col_m1 = WW'(col_q) - WW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      gradients.valid <= 1'b0;
    end else if (load) begin
      gradients.valid <= 1'b1;
    end else if (gradients.ready) begin
      gradients.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gradients.magnitude  <= calc_mag;
      gradients.direction  <= calc_dir;
      gradients.center_row <= row_q - 12'd1;
      gradients.center_col <= col_m1[10:0];
      gradients.frame_last <= last_q;
    end
  end

endmodule
`default_nettype wire

// File: design/sgd_checker.sv
`default_nettype none
module sgd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] out_direction,
  input wire logic [11:0] out_row
);

  // One pixel at a time: the cycle after an accept takes no new item.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted in the cycle after an accept");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_direction))
    else $error("stalled result changed");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_direction) <= 15'sd12868 &&
                   $signed(out_direction) >= -15'sd12868))
    else $error("direction outside plus or minus half pi");

  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row != 12'd0)
    else $error("result for a border row");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind sobel_gradient_direction sgd_checker u_sgd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixels.valid),
  .in_ready      (pixels.ready),
  .out_valid     (gradients.valid),
  .out_ready     (gradients.ready),
  .out_direction (gradients.direction),
  .out_row       (gradients.center_row)
);
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb;
  import sgd_pkg::*;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0]         magnitude;
    logic signed [14:0] direction;
    logic [11:0]        center_row;
    logic [10:0]        center_col;
    logic               frame_last;
  } grad_item_t;

  localparam longint ATAN_Q20 [CORDIC_STEPS] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };
  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sgd_pixel_if pin ();
  sgd_grad_if  gout ();

  sobel_gradient_direction i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pixels    (pin),
    .gradients (gout)
  );

  pixel_item_t pending_pixels [$];
  grad_item_t  expected_grads [$];
  int          error_count = 0;
  int          src_idle_pct = 23;
  int          sink_idle_pct = 23;
  bit          hold_request = 0;
  int          hold_left = 0;
  bit          pixel_taken = 0;
  int          item_count = 0;

  // Shadow of the block's state.
  logic [11:0] geo_width = 12'(FRAME_WIDTH_RESET);
  logic [12:0] geo_height = 13'(FRAME_HEIGHT_RESET);
  logic [7:0]  upper_row [MAX_WIDTH_DEFAULT];
  logic [7:0]  middle_row [MAX_WIDTH_DEFAULT];
  logic [7:0]  win [6];
  int          col_pos = 0;
  int          row_pos = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic logic [7:0] sat_root(input int n);
    int r;
    r = 0;
    while (r < MAG_MAX && (r + 1) * (r + 1) <= n) r++;
    return r[7:0];
  endfunction

  function automatic logic signed [14:0] cordic_angle(input int gx, input int gy);
    longint x, y, z, nx, q;
    x = (gx < 0 ? -gx : gx) * 64'sd1048576;
    y = (gy < 0 ? -gy : gy) * 64'sd1048576;
    z = 0;
    if (gx == 0) return gy > 0 ? 15'(HALF_PI_Q13) : -15'(HALF_PI_Q13);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_Q20[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_Q20[i];
      end
      x = nx;
    end
    q = (z + 64) >>> 7;
    if (q < 0) q = 0;
    if (q > HALF_PI_Q13) q = HALF_PI_Q13;
    if ((gx < 0) != (gy < 0)) q = -q;
    return q[14:0];
  endfunction

  task automatic predict_gradient(input pixel_item_t it);
    int w, h, top, mid, pix, gx, gy;
    grad_item_t g;
    w = geo_width < 3 ? 3 : (geo_width > MAX_WIDTH_DEFAULT ? MAX_WIDTH_DEFAULT : geo_width);
    h = geo_height < 3 ? 3 : (geo_height > MAX_HEIGHT ? MAX_HEIGHT : geo_height);
    if (it.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    pix = it.pixel;
    top = upper_row[col_pos];
    mid = middle_row[col_pos];
    upper_row[col_pos] = mid[7:0];
    middle_row[col_pos] = it.pixel;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (top + 2 * mid + pix) - (win[0] + 2 * win[1] + win[2]);
      gy = (win[0] + 2 * win[3] + top) - (win[2] + 2 * win[5] + pix);
      g.magnitude = sat_root(gx * gx + gy * gy);
      g.direction = cordic_angle(gx, gy);
      g.center_row = 12'(row_pos - 1);
      g.center_col = 11'(col_pos - 1);
      g.frame_last = (row_pos == h - 1 && col_pos == w - 1);
      expected_grads.push_back(g);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top[7:0];
    win[4] = mid[7:0];
    win[5] = it.pixel;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Pixel source: a new item is offered only once the previous one is taken.
  always @(posedge clk) begin
    pixel_taken = !rst && pin.valid && pin.ready;
    if (pixel_taken) predict_gradient('{pin.pixel, pin.frame_start});
  end

  always @(negedge clk) begin
    if (!rst && (!pin.valid || pixel_taken)) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        pixel_item_t it;
        it = pending_pixels.pop_front();
        pin.valid <= 1'b1;
        pin.pixel <= it.pixel;
        pin.frame_start <= it.frame_start;
      end else begin
        pin.valid <= 1'b0;
      end
    end
  end

  // Result sink, with a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 400;
    end
    if (rst) begin
      gout.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      gout.ready <= 1'b0;
    end else begin
      gout.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && gout.valid && gout.ready) begin
      if (expected_grads.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d",
                         gout.center_row, gout.center_col));
      end else begin
        grad_item_t g;
        g = expected_grads.pop_front();
        if (gout.magnitude !== g.magnitude)
          report($sformatf("magnitude %0d, expected %0d at (%0d,%0d)",
                           gout.magnitude, g.magnitude, g.center_row, g.center_col));
        if (gout.direction !== g.direction)
          report($sformatf("direction %0d, expected %0d at (%0d,%0d)",
                           gout.direction, g.direction, g.center_row, g.center_col));
        if (gout.center_row !== g.center_row)
          report($sformatf("center_row %0d, expected %0d", gout.center_row, g.center_row));
        if (gout.center_col !== g.center_col)
          report($sformatf("center_col %0d, expected %0d", gout.center_col, g.center_col));
        if (gout.frame_last !== g.frame_last)
          report($sformatf("frame_last %0b, expected %0b at (%0d,%0d)",
                           gout.frame_last, g.frame_last, g.center_row, g.center_col));
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_WIDTH) geo_width = data[11:0];
    else geo_height = data[12:0];
  endtask

  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && !pin.valid);
    wait (expected_grads.size() == 0);
    // Border pixels may still be in flight with nothing expected.
    repeat (40) @(negedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    wait_idle();
    apb_write(ADDR_WIDTH, w);
    apb_write(ADDR_HEIGHT, h);
  endtask

  task automatic add_pixel(input int value, input bit fs);
    pending_pixels.push_back('{value[7:0], fs});
    item_count++;
  endtask

  // Random pixels; when noisy, now and then a frame start in the middle of a frame.
  task automatic add_frame(input int count, input bit noisy);
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < count; i++) begin
      int v;
      case (mode)
        0: v = $urandom_range(1) ? 255 : 0;
        1: v = $urandom_range(3) ? 128 + $urandom_range(4) : $urandom_range(255);
        default: v = $urandom_range(255);
      endcase
      add_pixel(v, i == 0 || (noisy && $urandom_range(99) < 3));
    end
  endtask

  task automatic add_pattern(input int p [9]);
    for (int i = 0; i < 9; i++) add_pixel(p[i], i == 0);
  endtask

  initial begin
    int w, h;
    for (int i = 0; i < MAX_WIDTH_DEFAULT; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pin.valid = 1'b0;
    pin.pixel = '0;
    pin.frame_start = 1'b0;
    gout.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: flat window, gradient straight up, straight down, full right.
    set_geometry(3, 3);
    add_pattern('{7, 7, 7, 7, 7, 7, 7, 7, 7});
    add_pattern('{255, 255, 255, 0, 0, 0, 0, 0, 0});
    add_pattern('{0, 0, 0, 0, 0, 0, 255, 255, 255});
    add_pattern('{0, 0, 255, 0, 0, 255, 0, 0, 255});

    // Geometry below range clamps to 3x3.
    set_geometry(0, 0);
    add_frame(18, 0);

    // A shorter width while mid-frame wraps the position.
    set_geometry(10, 6);
    add_frame(35, 0);
    wait_idle();
    apb_write(ADDR_WIDTH, 6);
    add_frame(30, 0);
    pending_pixels[pending_pixels.size() - 30].frame_start = 1'b0;

    // Random frames of small size; one phase runs without idling.
    while (item_count < 420) begin
      w = $urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 14);
      h = $urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 7);
      set_geometry(w, h);
      if (item_count > 300 && item_count < 400) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = 23;
        sink_idle_pct = 23;
      end
      add_frame((w < 3 ? 3 : w) * (h < 3 ? 3 : h) * $urandom_range(1, 2), 1);
    end
    src_idle_pct = 23;
    sink_idle_pct = 23;

    // The sink holds off long enough to back up the input.
    set_geometry(6, 10);
    add_frame(60, 0);
    hold_request = 1;

    // Tallest frame, only its first rows.
    set_geometry(3, 4096);
    add_frame(60, 0);

    // Geometry above range clamps to 2048 by 4096.
    set_geometry(4095, 8191);
    add_frame(40, 0);

    set_geometry(5, 4);
    add_frame(40, 1);
    wait_idle();

    if (expected_grads.size() != 0) report("results still expected at end of run");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
